@@ rtl/line_ring_buffer_macros.svh @@
// Assertion macros shared by the line ring buffer RTL.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef LINE_RING_BUFFER_MACROS_SVH
`define LINE_RING_BUFFER_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define LRB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that, when seen, requires a consequence in the same cycle.
`define LRB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/lrb_pkg.sv @@
`default_nettype none

package lrb_pkg;

  // Configuration port geometry.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int FLAG_W    = 5;
  localparam int FILLO_W   = 5;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE  = 2'd0,
    CFG_LINES = 2'd1,
    CFG_LEN   = 2'd2
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [1:0]       MODE_RST  = 2'd0;
  localparam logic [CFG_W-1:0] LINES_RST = 5'd16;
  localparam logic [CFG_W-1:0] LEN_RST   = 5'd16;

  // Overwrite policies.
  localparam logic [1:0] MODE_DROP_OLDEST    = 2'd0;
  localparam logic [1:0] MODE_RESTART_NEWEST = 2'd1;

  // Input action codes.
  localparam logic [2:0] ACT_PUSH      = 3'd0;
  localparam logic [2:0] ACT_COMMIT    = 3'd1;
  localparam logic [2:0] ACT_POP       = 3'd2;
  localparam logic [2:0] ACT_CLEAR     = 3'd3;
  localparam logic [2:0] ACT_CLR_FLAGS = 3'd4;

  // Consumer verdicts on a pop.
  localparam logic [1:0] VERD_DROP = 2'd1;
  localparam logic [1:0] VERD_TAKE = 2'd2;

  // Event flag bit positions.
  localparam int FLG_OVERWRITE = 0;
  localparam int FLG_FULL      = 1;
  localparam int FLG_EMPTY     = 2;
  localparam int FLG_WRAPPED   = 3;
  localparam int FLG_READY     = 4;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_NOT_READY = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_e;

  // Decoded operation handed from the front to the back.
  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_COMMIT    = 3'd1,
    OP_POP_WAIT  = 3'd2,
    OP_POP_DROP  = 3'd3,
    OP_POP_TAKE  = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_CLR_FLAGS = 3'd6,
    OP_NOP       = 3'd7
  } op_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CFG_W-1:0] lines;
    logic [CFG_W-1:0] len;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [7:0]        data;
    logic [FLAG_W-1:0] mask;
  } q_item_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               last;
    logic [FILLO_W-1:0] popped_count;
    logic [FILLO_W-1:0] read_fill;
    logic [FILLO_W-1:0] write_fill;
    logic [FLAG_W-1:0]  flags;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/lrb_front.sv @@
`default_nettype none

module lrb_front import lrb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [1:0]  pop_verdict_i,
  input  wire logic [FLAG_W-1:0] flag_mask_i,
  output logic             q_valid_o,
  output q_item_t          q_item_o,
  input  wire logic        q_pop_i
);

  localparam int QDEPTH = 2;
  localparam int QCW    = $clog2(QDEPTH + 1);

  q_item_t          entry_q [QDEPTH];
  q_item_t          item;
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]   cnt_q, cnt_d;
  logic             push;

  // Classify the incoming transaction into one operation.
  always_comb begin
    item.data = data_byte_i;
    item.mask = flag_mask_i;
    unique case (action_i)
      ACT_PUSH:      item.op = OP_PUSH;
      ACT_COMMIT:    item.op = OP_COMMIT;
      ACT_POP: begin
        unique case (pop_verdict_i)
          VERD_DROP: item.op = OP_POP_DROP;
          VERD_TAKE: item.op = OP_POP_TAKE;
          default:   item.op = OP_POP_WAIT;
        endcase
      end
      ACT_CLEAR:     item.op = OP_CLEAR;
      ACT_CLR_FLAGS: item.op = OP_CLR_FLAGS;
      default:       item.op = OP_NOP;
    endcase
  end

  // Two-entry queue toward the back end.
  assign in_stall_o = (cnt_q == QCW'(QDEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = entry_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + QCW'(1);
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lrb_back.sv @@
`default_nettype none
`include "line_ring_buffer_macros.svh"

module lrb_back import lrb_pkg::*; #(
  parameter int NUM_LINES = 16,
  parameter int LINE_LEN  = 16
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire logic    q_valid_i,
  input  wire q_item_t q_item_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output res_t         res_o
);

  localparam int LW    = $clog2(NUM_LINES);
  localparam int LCW   = $clog2(NUM_LINES + 1);
  localparam int FW    = $clog2(LINE_LEN + 1);
  localparam int DEPTH = NUM_LINES * LINE_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = LCW + FW;

  // Geometry after reset, the reset register values saturated.
  localparam int RstLines = (NUM_LINES < int'(LINES_RST)) ? NUM_LINES : int'(LINES_RST);
  localparam int RstLen   = (LINE_LEN < int'(LEN_RST)) ? LINE_LEN : int'(LEN_RST);
  localparam int RstRbase = (RstLines - 1) * RstLen;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_EMIT  = 4'b0100,
    S_BYTES = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [LW-1:0]     write_q, write_d, read_q, read_d;
  logic [AW-1:0]     wbase_q, wbase_d, rbase_q, rbase_d;
  logic [FW-1:0]     wfill_q, wfill_d, rfill_q, rfill_d;
  logic [FLAG_W-1:0] flags_q, flags_d;
  logic [LCW-1:0]    geo_lines_q, geo_lines_d;
  logic [FW-1:0]     geo_len_q, geo_len_d;
  status_e           status_q, status_d;
  logic [AW-1:0]     pop_addr_q, pop_addr_d;
  logic [FW-1:0]     rd_left_q, rd_left_d, out_left_q, out_left_d;
  logic [FW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  logic [FW-1:0]     fill_mem [NUM_LINES];
  logic [FW-1:0]     fill_rdata_q;
  logic              fill_we, fill_re;
  logic [7:0]        store_mem [DEPTH];
  logic [7:0]        store_rdata_q;
  logic              store_we, store_re;
  logic [AW-1:0]     store_waddr, store_raddr;

  logic [LW-1:0]     next_w, next_r;
  logic [AW-1:0]     next_wb, next_rb;
  logic [LCW-1:0]    lines_sat;
  logic [FW-1:0]     len_sat;
  logic [PW-1:0]     rbase_prod;
  logic              out_free, res_load, clob, full, ovw;
  logic              adv_w, drop_r, restart_w, do_seek, append, need_fetch;
  logic              out_load, issue;

  function automatic logic [LW-1:0] next_idx(input logic [LW-1:0] idx,
                                             input logic [LCW-1:0] lines);
    logic [LCW-1:0] inc;
    inc = LCW'(idx) + LCW'(1);
    if (inc >= lines) begin
      return '0;
    end
    return LW'(inc);
  endfunction

  function automatic res_t make_res(input status_e st, input logic [7:0] b,
                                    input logic bv, input logic lst,
                                    input logic [FW-1:0] cnt, input logic [FW-1:0] rf,
                                    input logic [FW-1:0] wf,
                                    input logic [FLAG_W-1:0] fl);
    res_t r;
    r.status       = st;
    r.out_byte     = b;
    r.byte_valid   = bv;
    r.last         = lst;
    r.popped_count = FILLO_W'(cnt);
    r.read_fill    = FILLO_W'(rf);
    r.write_fill   = FILLO_W'(wf);
    r.flags        = fl;
    return r;
  endfunction

  // Neighbor lines and their base addresses in the byte store.
  assign next_w  = next_idx(write_q, geo_lines_q);
  assign next_r  = next_idx(read_q, geo_lines_q);
  assign next_wb = (next_w == '0) ? '0 : wbase_q + AW'(geo_len_q);
  assign next_rb = (next_r == '0) ? '0 : rbase_q + AW'(geo_len_q);

  // Geometry taken from the registers at a ring clear, saturated into range.
  always_comb begin
    if (cfg_i.lines < CFG_W'(2)) begin
      lines_sat = LCW'(2);
    end else if (32'(cfg_i.lines) > NUM_LINES) begin
      lines_sat = LCW'(NUM_LINES);
    end else begin
      lines_sat = LCW'(cfg_i.lines);
    end
    if (cfg_i.len == '0) begin
      len_sat = FW'(1);
    end else if (32'(cfg_i.len) > LINE_LEN) begin
      len_sat = FW'(LINE_LEN);
    end else begin
      len_sat = FW'(cfg_i.len);
    end
    rbase_prod = PW'(lines_sat - LCW'(1)) * PW'(len_sat);
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign clob     = (next_w == read_q);
  assign full     = (wfill_q >= geo_len_q);
  assign out_load = pend_q && out_free;
  assign issue    = (rd_left_q != '0) && (!pend_q || out_load);

  // Execution sequencer.
  always_comb begin
    state_d     = state_q;
    write_d     = write_q;
    read_d      = read_q;
    wbase_d     = wbase_q;
    rbase_d     = rbase_q;
    wfill_d     = wfill_q;
    rfill_d     = rfill_q;
    flags_d     = flags_q;
    geo_lines_d = geo_lines_q;
    geo_len_d   = geo_len_q;
    status_d    = status_q;
    pop_addr_d  = pop_addr_q;
    rd_left_d   = rd_left_q;
    out_left_d  = out_left_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    res_d       = res_q;
    res_load    = 1'b0;
    q_pop_o     = 1'b0;
    fill_we     = 1'b0;
    fill_re     = 1'b0;
    store_we    = 1'b0;
    store_re    = 1'b0;
    store_waddr = wbase_q;
    store_raddr = pop_addr_q;
    ovw         = 1'b0;
    adv_w       = 1'b0;
    drop_r      = 1'b0;
    restart_w   = 1'b0;
    do_seek     = 1'b0;
    append      = 1'b0;
    need_fetch  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o    = 1'b1;
          status_d   = ST_DONE;
          rd_left_d  = '0;
          out_left_d = '0;
          unique case (q_item_i.op)
            OP_PUSH, OP_COMMIT: begin
              if (clob) begin
                flags_d[FLG_FULL] = 1'b1;
              end
              if (full) begin
                flags_d[FLG_WRAPPED] = 1'b1;
              end
              ovw = (q_item_i.op == OP_PUSH) ? (clob && full) : clob;
              if (ovw && cfg_i.mode == MODE_DROP_OLDEST) begin
                drop_r = 1'b1;
                adv_w  = 1'b1;
                flags_d[FLG_OVERWRITE] = 1'b1;
              end else if (ovw && cfg_i.mode == MODE_RESTART_NEWEST) begin
                restart_w = 1'b1;
                flags_d[FLG_OVERWRITE] = 1'b1;
              end else if (ovw) begin
                status_d = ST_REFUSED;
              end else if (q_item_i.op == OP_COMMIT || full) begin
                adv_w = 1'b1;
              end
              append = (q_item_i.op == OP_PUSH) && !(ovw && cfg_i.mode != MODE_DROP_OLDEST
                       && cfg_i.mode != MODE_RESTART_NEWEST);
              if (q_item_i.op == OP_COMMIT) begin
                flags_d[FLG_READY] = 1'b1;
              end
            end
            OP_POP_WAIT: begin
              status_d = ST_NOT_READY;
            end
            OP_POP_DROP: begin
              status_d = ST_TRUNCATED;
              do_seek  = 1'b1;
            end
            OP_POP_TAKE: begin
              cnt_d      = rfill_q;
              pop_addr_d = rbase_q;
              rd_left_d  = rfill_q;
              out_left_d = rfill_q;
              do_seek    = 1'b1;
            end
            OP_CLEAR: begin
              geo_lines_d = lines_sat;
              geo_len_d   = len_sat;
              write_d     = '0;
              read_d      = LW'(lines_sat - LCW'(1));
              wbase_d     = '0;
              rbase_d     = AW'(rbase_prod);
              wfill_d     = '0;
              rfill_d     = '0;
              flags_d     = '0;
            end
            OP_CLR_FLAGS: begin
              flags_d = flags_q & ~q_item_i.mask;
            end
            OP_NOP: begin
            end
          endcase

          // Dropping the oldest line: the new read line's fill is looked up,
          // or taken from the write line when the two are neighbors.
          if (drop_r) begin
            read_d  = next_r;
            rbase_d = next_rb;
            if (next_r == write_q) begin
              rfill_d = wfill_q;
            end else begin
              need_fetch = 1'b1;
            end
          end
          // Seek past the read line unless the ring would run empty.
          if (do_seek) begin
            rfill_d = '0;
            if (next_r == write_q) begin
              flags_d[FLG_EMPTY] = 1'b1;
            end else begin
              read_d     = next_r;
              rbase_d    = next_rb;
              need_fetch = 1'b1;
            end
          end
          // Leaving the write line stores its fill for the reader.
          if (adv_w) begin
            fill_we = 1'b1;
            write_d = next_w;
            wbase_d = next_wb;
            wfill_d = '0;
          end
          if (restart_w) begin
            wfill_d = '0;
          end
          if (append) begin
            store_we    = 1'b1;
            store_waddr = wbase_d + AW'(wfill_d);
            wfill_d     = wfill_d + FW'(1);
          end

          if (need_fetch) begin
            fill_re = 1'b1;
            state_d = S_FETCH;
          end else if (rd_left_d != '0) begin
            state_d = S_BYTES;
          end else begin
            res_load = 1'b1;
            res_d    = make_res(status_d, 8'd0, 1'b0, 1'b1, '0, rfill_d, wfill_d,
                                flags_d);
          end
        end
      end

      S_FETCH: begin
        rfill_d = fill_rdata_q;
        state_d = (out_left_q != '0) ? S_BYTES : S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          res_load = 1'b1;
          res_d    = make_res(status_q, 8'd0, 1'b0, 1'b1, '0, rfill_q, wfill_q, flags_q);
          state_d  = S_IDLE;
        end
      end

      S_BYTES: begin
        // Store reads run one ahead of the output register.
        if (issue) begin
          store_re   = 1'b1;
          pop_addr_d = pop_addr_q + AW'(1);
          rd_left_d  = rd_left_q - FW'(1);
        end
        pend_d = issue ? 1'b1 : (out_load ? 1'b0 : pend_q);
        if (out_load) begin
          res_load   = 1'b1;
          res_d      = make_res(ST_DONE, store_rdata_q, 1'b1, out_left_q == FW'(1), cnt_q,
                                rfill_q, wfill_q, flags_q);
          out_left_d = out_left_q - FW'(1);
          if (out_left_q == FW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      write_q     <= '0;
      read_q      <= LW'(RstLines - 1);
      wbase_q     <= '0;
      rbase_q     <= AW'(RstRbase);
      wfill_q     <= '0;
      rfill_q     <= '0;
      flags_q     <= '0;
      geo_lines_q <= LCW'(RstLines);
      geo_len_q   <= FW'(RstLen);
      rd_left_q   <= '0;
      out_left_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      write_q     <= write_d;
      read_q      <= read_d;
      wbase_q     <= wbase_d;
      rbase_q     <= rbase_d;
      wfill_q     <= wfill_d;
      rfill_q     <= rfill_d;
      flags_q     <= flags_d;
      geo_lines_q <= geo_lines_d;
      geo_len_q   <= geo_len_d;
      rd_left_q   <= rd_left_d;
      out_left_q  <= out_left_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    pop_addr_q <= pop_addr_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
  end

  // Fill count memory for lines the writer has left.
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[write_q] <= wfill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_re) begin
      fill_rdata_q <= fill_mem[next_r];
    end
  end

  // Byte store.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_waddr] <= q_item_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_re) begin
      store_rdata_q <= store_mem[store_raddr];
    end
  end

  // The reader and the writer never share a line.
  `LRB_ASSERT(a_lines_disjoint, read_q != write_q, "read and write line coincide")
  // Both line indices stay inside the active ring.
  `LRB_ASSERT(a_idx_range, (LCW'(write_q) < geo_lines_q) && (LCW'(read_q) < geo_lines_q),
              "line index outside the ring")
  // Fill counts never exceed the active line length.
  `LRB_ASSERT(a_fill_bound, (wfill_q <= geo_len_q) && (rfill_q <= geo_len_q),
              "line fill beyond line length")
  // A store read in flight only exists while bytes are streamed out.
  `LRB_ASSERT_IMP(a_pend_in_bytes, pend_q, state_q == S_BYTES,
                  "store read pending outside byte streaming")

endmodule

`default_nettype wire

@@ rtl/line_ring_buffer.sv @@
// Line ring buffer: a ring of byte lines with a selectable overwrite policy.
// Input channel (in_valid_i / in_stall_o) carries one action per transaction:
// push a byte, commit the write line, pop the read line, clear the ring or
// clear event flags. Output channel (out_valid_o / out_stall_i) returns one
// result per transaction, or one result per byte for a ready pop.
// Configuration writes (cfg_valid_i / cfg_ready_o) set the overwrite mode and
// the ring geometry; geometry takes effect at reset and at a clear.
// Each result passes through the two-entry input queue and the output
// register; pushes, commits, waits and clears sustain one per cycle while the
// output is not stalled and no lookup is needed. An item that needs the fill
// count of a new read line first visits S_FETCH for the fill-count memory
// lookup. A ready pop of k bytes reads the byte store one byte ahead of the
// output register and presents one result per cycle while the output is not
// stalled; an empty line gives a single result.
// Reset empties the ring at once with the reset geometry; no clearing pass.
// A stalled result holds the output register; the two-entry input queue then
// fills and raises in_stall_o.
`default_nettype none

module line_ring_buffer import lrb_pkg::*; #(
  parameter int NUM_LINES = 16,
  parameter int LINE_LEN  = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [2:0]           action_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic [1:0]           pop_verdict_i,
  input  wire logic [FLAG_W-1:0]    flag_mask_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [1:0]                status_o,
  output logic [7:0]                out_byte_o,
  output logic                      byte_valid_o,
  output logic                      last_o,
  output logic [FILLO_W-1:0]        popped_count_o,
  output logic [FILLO_W-1:0]        read_line_fill_o,
  output logic [FILLO_W-1:0]        write_line_fill_o,
  output logic [FLAG_W-1:0]         flags_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t    cfg_q;
  logic    q_valid, q_pop;
  q_item_t q_item;
  res_t    res;

  // Configuration registers, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode  <= MODE_RST;
      cfg_q.lines <= LINES_RST;
      cfg_q.len   <= LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODE:  cfg_q.mode  <= cfg_data_i[1:0];
        CFG_LINES: cfg_q.lines <= cfg_data_i;
        CFG_LEN:   cfg_q.len   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  lrb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .data_byte_i   (data_byte_i),
    .pop_verdict_i (pop_verdict_i),
    .flag_mask_i   (flag_mask_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  lrb_back #(
    .NUM_LINES (NUM_LINES),
    .LINE_LEN  (LINE_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  // Result fields onto their ports.
  assign status_o          = res.status;
  assign out_byte_o        = res.out_byte;
  assign byte_valid_o      = res.byte_valid;
  assign last_o            = res.last;
  assign popped_count_o    = res.popped_count;
  assign read_line_fill_o  = res.read_fill;
  assign write_line_fill_o = res.write_fill;
  assign flags_o           = res.flags;

endmodule

`default_nettype wire
